// ===== rtl/core/btqc_pkg.sv =====
// shared types, constants and codes of the burst time quantum calculator
package btqc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int BURST_W         = 16;
    localparam int QUANT_W         = 21;
    localparam int MODE_W          = 2;
    localparam int PROD_W          = 2 * BURST_W;

    localparam logic [QUANT_W-1:0] PIT_RATE    = 21'd1193182;
    localparam logic [QUANT_W-1:0] RANGE_LIMIT = 21'd1000;

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_KEEP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RANGE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SQRT   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_MEDIAN;

    // result source select
    localparam logic [2:0] SRC_LAST = 3'd0;
    localparam logic [2:0] SRC_DIV  = 3'd1;
    localparam logic [2:0] SRC_MED  = 3'd2;
    localparam logic [2:0] SRC_SQRT = 3'd3;
    localparam logic [2:0] SRC_ERR  = 3'd4;

    typedef struct packed {
        logic       load;
        logic       piv_ld;
        logic       sel_j;
        logic       j_step;
        logic       rank_end;
        logic       med_calc;
        logic       div1_start;
        logic       div2_start;
        logic       prod_ld;
        logic       sq_start;
        logic       res_ld;
        logic [2:0] res_src;
    } cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic              in_is_last;
        logic [MODE_W-1:0] mode;
        logic              range_bad;
        logic              i_last;
        logic              j_last;
        logic              div_done;
        logic              sq_done;
        logic              out_free;
    } sts_t;

endpackage

// ===== rtl/core/burst_time_quantum_calculator.sv =====
// top level of the burst time quantum calculator
//
// Input channel (in_valid/in_ready, burst, is_last): one burst per beat. Up to
// MAX_ENTRIES bursts are held per set; further ones are dropped. A beat with
// is_last closes the set and starts the calculation selected by the mode
// register (cfg_we/cfg_wdata, written only while idle: a user rule, unchecked).
// Output channel (out_valid/out_ready, quantum, error): one beat per set.
// After a last burst, in_ready stays low
// until the result is loaded into the output register:
//   mode 0: the last quantum; mode 1: two 21-step divisions (error if the
//           range is zero or above 1000); mode 2: the median, set by the
//           ranking scan, which reads the store's single read port once per
//           compare pair; mode 3: as mode 2 plus the 16-step square root.
// The output register frees the input side: bursts of the next set are taken
// while a result waits; a finished calculation holds until out_ready clears
// the slot.
// Reset clears the set, sets mode to median and the last quantum to zero.
module burst_time_quantum_calculator #(
    parameter int MAX_ENTRIES = btqc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [btqc_pkg::MODE_W-1:0]     cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [btqc_pkg::BURST_W-1:0]    burst,
    input  logic                            is_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [btqc_pkg::QUANT_W-1:0]    quantum,
    output logic                            error
);
    import btqc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    btqc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    btqc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .burst     (burst),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quantum   (quantum),
        .error     (error)
    );

endmodule

// ===== rtl/core/btqc_div.sv =====
// restoring divider, one quotient bit per cycle
module btqc_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [btqc_pkg::QUANT_W-1:0]    dividend,
    input  logic [btqc_pkg::QUANT_W-1:0]    divisor,
    output logic [btqc_pkg::QUANT_W-1:0]    quotient,
    output logic                            done
);
    import btqc_pkg::*;

    localparam int SW = $clog2(QUANT_W + 1);

    logic [QUANT_W-1:0] quo_reg;
    logic [QUANT_W-1:0] rem_reg;
    logic [QUANT_W-1:0] dvs_reg;
    logic [SW-1:0]      step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [QUANT_W:0]   rem_sh;
    logic               fits;

    // trial subtract of shifted remainder
    assign rem_sh = {rem_reg, quo_reg[QUANT_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(QUANT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= QUANT_W'(rem_sh - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[QUANT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[QUANT_W-1:0];
                quo_reg <= {quo_reg[QUANT_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/btqc_sqrt.sv =====
// digit by digit integer square root, one root bit per cycle
module btqc_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [btqc_pkg::PROD_W-1:0]     radicand,
    output logic [btqc_pkg::BURST_W-1:0]    root,
    output logic                            done
);
    import btqc_pkg::*;

    localparam int SW = $clog2(BURST_W + 1);
    localparam int RW = BURST_W + 2;

    logic [PROD_W-1:0]  val_reg;
    logic [BURST_W-1:0] root_reg;
    logic [RW-1:0]      rem_reg;
    logic [SW-1:0]      step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [RW+1:0]      rem_sh;
    logic [RW+1:0]      trial;
    logic               fits;

    assign rem_sh = {rem_reg, val_reg[PROD_W-1:PROD_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(BURST_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[PROD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= RW'(rem_sh - trial);
                root_reg <= {root_reg[BURST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= RW'(rem_sh);
                root_reg <= {root_reg[BURST_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/btqc_ctrl.sv =====
// sequencing state machine of the quantum calculator
module btqc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  btqc_pkg::sts_t  sts,
    output btqc_pkg::cmd_t  cmd,
    output logic            in_ready
);
    import btqc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RCHK = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_DIV2 = 4'd3;
    localparam logic [3:0] S_PRD  = 4'd4;
    localparam logic [3:0] S_PLD  = 4'd5;
    localparam logic [3:0] S_JRD  = 4'd6;
    localparam logic [3:0] S_JCMP = 4'd7;
    localparam logic [3:0] S_REND = 4'd8;
    localparam logic [3:0] S_MED  = 4'd9;
    localparam logic [3:0] S_PROD = 4'd10;
    localparam logic [3:0] S_SQS  = 4'd11;
    localparam logic [3:0] S_SQW  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] src_reg;
    logic [2:0] src_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        cmd        = '0;
        cmd.res_src = src_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_is_last)
                    begin
                        case (sts.mode)
                            MODE_KEEP:
                            begin
                                src_next   = SRC_LAST;
                                state_next = S_DONE;
                            end
                            MODE_RANGE:
                            begin
                                state_next = S_RCHK;
                            end
                            default:
                            begin
                                state_next = S_PRD;
                            end
                        endcase
                    end
                end
            end
            S_RCHK:
            begin
                if (sts.range_bad)
                begin
                    src_next   = SRC_ERR;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div1_start = 1'b1;
                    state_next     = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (sts.div_done)
                begin
                    cmd.div2_start = 1'b1;
                    state_next     = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (sts.div_done)
                begin
                    src_next   = SRC_DIV;
                    state_next = S_DONE;
                end
            end
            S_PRD:
            begin
                state_next = S_PLD;
            end
            S_PLD:
            begin
                cmd.piv_ld = 1'b1;
                state_next = S_JRD;
            end
            S_JRD:
            begin
                cmd.sel_j  = 1'b1;
                state_next = S_JCMP;
            end
            S_JCMP:
            begin
                cmd.j_step = 1'b1;
                state_next = sts.j_last ? S_REND : S_JRD;
            end
            S_REND:
            begin
                cmd.rank_end = 1'b1;
                state_next   = sts.i_last ? S_MED : S_PRD;
            end
            S_MED:
            begin
                cmd.med_calc = 1'b1;
                if (sts.mode == MODE_SQRT)
                begin
                    state_next = S_PROD;
                end
                else
                begin
                    src_next   = SRC_MED;
                    state_next = S_DONE;
                end
            end
            S_PROD:
            begin
                cmd.prod_ld = 1'b1;
                state_next  = S_SQS;
            end
            S_SQS:
            begin
                cmd.sq_start = 1'b1;
                state_next   = S_SQW;
            end
            S_SQW:
            begin
                if (sts.sq_done)
                begin
                    src_next   = SRC_SQRT;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_reg   <= SRC_LAST;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/core/btqc_dp.sv =====
// datapath: burst store, ranking scan, median, divider and root units, result register
module btqc_dp #(
    parameter int MAX_ENTRIES = btqc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  btqc_pkg::cmd_t                  cmd,
    output btqc_pkg::sts_t                  sts,
    input  logic                            cfg_we,
    input  logic [btqc_pkg::MODE_W-1:0]     cfg_wdata,
    input  logic                            in_valid,
    input  logic [btqc_pkg::BURST_W-1:0]    burst,
    input  logic                            is_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [btqc_pkg::QUANT_W-1:0]    quantum,
    output logic                            error
);
    import btqc_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [BURST_W-1:0] mem [MAX_ENTRIES];
    logic [BURST_W-1:0] rd_data_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      rank_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [QUANT_W-1:0] last_q_reg;
    logic               out_valid_reg;
    logic [QUANT_W-1:0] quantum_reg;
    logic               error_reg;
    logic [BURST_W-1:0] min_reg;
    logic [BURST_W-1:0] max_reg;
    logic [BURST_W-1:0] pivot_reg;
    logic [BURST_W-1:0] lo_reg;
    logic [BURST_W-1:0] hi_reg;
    logic [BURST_W-1:0] med_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic               room;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      half;
    logic               even;
    logic               less;
    logic [BURST_W-1:0] range;
    logic               out_free;
    logic [QUANT_W-1:0] res_q_next;
    logic               div_start;
    logic [QUANT_W-1:0] div_dividend;
    logic [QUANT_W-1:0] div_divisor;
    logic [QUANT_W-1:0] div_quo;
    logic               div_done;
    logic [BURST_W-1:0] sq_root;
    logic               sq_done;

    assign room     = cnt_reg < CW'(MAX_ENTRIES);
    assign rd_addr  = cmd.sel_j ? j_reg[AW-1:0] : i_reg[AW-1:0];
    assign half     = cnt_reg >> 1;
    assign even     = ~cnt_reg[0];
    assign less     = (rd_data_reg < pivot_reg)
                      || ((rd_data_reg == pivot_reg) && (j_reg < i_reg));
    assign range    = max_reg - min_reg;
    assign out_free = !out_valid_reg || out_ready;

    // burst store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            mem[cnt_reg[AW-1:0]] <= burst;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // running min and max of the held set
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            if (cnt_reg == '0)
            begin
                min_reg <= burst;
                max_reg <= burst;
            end
            else
            begin
                if (burst < min_reg)
                begin
                    min_reg <= burst;
                end
                if (burst > max_reg)
                begin
                    max_reg <= burst;
                end
            end
        end
    end

    // ranking scan: rank of each pivot, ties broken by position
    always_ff @(posedge clk)
    begin
        if (cmd.piv_ld)
        begin
            pivot_reg <= rd_data_reg;
        end
        if (cmd.rank_end)
        begin
            if (rank_reg == half)
            begin
                hi_reg <= pivot_reg;
            end
            if (even && (rank_reg == half - CW'(1)))
            begin
                lo_reg <= pivot_reg;
            end
        end
        if (cmd.med_calc)
        begin
            med_reg <= even ? BURST_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1) : hi_reg;
        end
        if (cmd.prod_ld)
        begin
            prod_reg <= med_reg * max_reg;
        end
    end

    // divider operands: 1000 / range, then rate / that
    assign div_start    = cmd.div1_start || cmd.div2_start;
    assign div_dividend = cmd.div2_start ? PIT_RATE : RANGE_LIMIT;
    assign div_divisor  = cmd.div2_start ? div_quo : QUANT_W'(range);

    btqc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    btqc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sq_start),
        .radicand (prod_reg),
        .root     (sq_root),
        .done     (sq_done)
    );

    // result select
    always_comb
    begin
        case (cmd.res_src)
            SRC_LAST: res_q_next = last_q_reg;
            SRC_DIV:  res_q_next = div_quo;
            SRC_MED:  res_q_next = QUANT_W'(med_reg);
            SRC_SQRT: res_q_next = QUANT_W'(sq_root);
            default:  res_q_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_ld)
        begin
            quantum_reg <= res_q_next;
            error_reg   <= (cmd.res_src == SRC_ERR);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            mode_reg      <= MODE_RESET;
            last_q_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                i_reg <= '0;
                if (room)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (cmd.piv_ld)
            begin
                j_reg    <= '0;
                rank_reg <= '0;
            end
            if (cmd.j_step)
            begin
                j_reg    <= j_reg + CW'(1);
                rank_reg <= rank_reg + CW'(less);
            end
            if (cmd.rank_end)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.res_ld)
            begin
                cnt_reg       <= '0;
                rank_reg      <= '0;
                out_valid_reg <= 1'b1;
                if ((cmd.res_src == SRC_DIV) || (cmd.res_src == SRC_MED)
                    || (cmd.res_src == SRC_SQRT))
                begin
                    last_q_reg <= res_q_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status to controller
    always_comb
    begin
        sts            = '0;
        sts.in_valid   = in_valid;
        sts.in_is_last = is_last;
        sts.mode       = mode_reg;
        sts.range_bad  = (range == '0) || (QUANT_W'(range) > RANGE_LIMIT);
        sts.i_last     = (i_reg == cnt_reg - CW'(1));
        sts.j_last     = (j_reg == cnt_reg - CW'(1));
        sts.div_done   = div_done;
        sts.sq_done    = sq_done;
        sts.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign quantum   = quantum_reg;
    assign error     = error_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ENTRIES))
        else $error("entry count past store depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg) |-> (quantum_reg == '0))
        else $error("error beat with nonzero quantum");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_ld |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg <= cnt_reg)
        else $error("rank exceeds set size");

endmodule
